/* hw/rtl/sps_pkg.sv */
// shared constants for the simhash projection signature block
// no dependencies
package sps_pkg;
    localparam int MAX_DIM      = 4096;
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_SIG_BITS = 63;
    localparam int SUM_W        = 46;
    localparam int CNT_W        = 13;
    localparam int BIT_W        = 6;
    localparam logic [63:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2  = 64'h94d049bb133111eb;
    localparam logic [63:0] BIT_MUL = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] IDX_MUL = 64'hd6e8feb86659fd93;
    localparam logic [0:0] REG_SIG_BITS = 1'b0;
    localparam logic [0:0] REG_SEED     = 1'b1;
endpackage

/* hw/rtl/sps_ram.sv */
// generic simple dual-port ram, registered read
// no dependencies
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/sps_hash.sv */
// pipelined splitmix64 finalizer, five stages, 32x32 partial products
// depends on sps_pkg
module sps_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] in_x,
    input  logic [5:0]  in_tag,
    output logic        out_valid,
    output logic [63:0] out_h,
    output logic [5:0]  out_tag
);
    logic [4:0]  v_reg;
    logic [5:0]  tag_reg [5];
    logic [63:0] x1_reg, y2_reg, h_reg;
    logic [63:0] a_ll_reg, b_ll_reg;
    logic [31:0] a_lh_reg, a_hl_reg, b_lh_reg, b_hl_reg;
    logic [63:0] y_next, z_next, x1_next, y2_next;
    logic [63:0] t_lh, t_hl, u_lh, u_hl;

    always_comb
    begin
        x1_next = in_x ^ (in_x >> 30);
        y_next  = a_ll_reg + {a_lh_reg + a_hl_reg, 32'd0};
        y2_next = y_next ^ (y_next >> 27);
        z_next  = b_ll_reg + {b_lh_reg + b_hl_reg, 32'd0};
        t_lh    = x1_reg[31:0] * sps_pkg::MIX_C1[63:32];
        t_hl    = x1_reg[63:32] * sps_pkg::MIX_C1[31:0];
        u_lh    = y2_reg[31:0] * sps_pkg::MIX_C2[63:32];
        u_hl    = y2_reg[63:32] * sps_pkg::MIX_C2[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int i = 1; i < 5; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        x1_reg   <= x1_next;
        a_ll_reg <= x1_reg[31:0] * sps_pkg::MIX_C1[31:0];
        a_lh_reg <= t_lh[31:0];
        a_hl_reg <= t_hl[31:0];
        y2_reg   <= y2_next;
        b_ll_reg <= y2_reg[31:0] * sps_pkg::MIX_C2[31:0];
        b_lh_reg <= u_lh[31:0];
        b_hl_reg <= u_hl[31:0];
        h_reg    <= z_next ^ (z_next >> 31);
    end

    assign out_valid = v_reg[4];
    assign out_h     = h_reg;
    assign out_tag   = tag_reg[4];
endmodule

/* hw/rtl/simhash_projection_signature.sv */
// simhash projection signature top level: sequencer, sum memory, output register
// depends on sps_pkg, sps_ram, sps_hash
// an element is taken and its hashes are issued one per cycle, one per signature bit
// in use (n), and ready returns once all its sums are written; with n = 0 none is issued
// the marked element adds sign readout and load, the load held while the output is full;
// the result is valid the cycle after, then a clearing pass; throughput is one signature bit per cycle
// reset is asynchronous active low; after reset a clearing pass runs before
// the first element transaction is taken; config transactions are taken at any time
module simhash_projection_signature (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] element_value
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [62:0] signature_value, [75:63] element_total,
                                   // [76] too_long, [79:77] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_SIG   = 3'd4;
    localparam logic [2:0] ST_SIGW  = 3'd5;
    localparam logic [2:0] ST_LOAD  = 3'd6;

    localparam int AW = $clog2(sps_pkg::MAX_SIG_BITS);
    localparam int SAMPLE_BITS_W = sps_pkg::SAMPLE_BITS;

    // configuration
    logic [5:0]  sig_bits_reg;
    logic [63:0] seed_reg;

    // control state
    logic [2:0]  state_reg, state_next;
    logic [sps_pkg::CNT_W-1:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [63:0] iterm_reg, iterm_next;   // count * IDX_MUL, kept as running sum
    logic [63:0] base_reg, base_next;
    logic [63:0] bterm_reg, bterm_next;   // b * BIT_MUL, running sum
    logic [5:0]  b_reg, b_next;
    logic        last_reg, last_next;
    logic [6:0]  inflight_reg, inflight_next;
    logic signed [15:0] elem_reg, elem_next;

    // sign readout
    logic        rdp_reg;
    logic [5:0]  rdi_reg;
    logic [62:0] sig_reg, sig_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [79:0] m_data_reg, m_data_next;

    // hash pipeline and accumulate stages
    logic        h_valid;
    logic [63:0] h_val;
    logic [5:0]  h_tag;
    logic        issue;
    logic        p_valid_reg;
    logic [5:0]  p_b_reg;
    logic        p_neg_reg;
    logic signed [33:0] prod_reg;
    logic signed [18:0] weight;
    logic signed [SAMPLE_BITS_W-1:0] unused_sb;

    // ram ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [sps_pkg::SUM_W-1:0] ram_wdata, ram_rdata;
    logic [sps_pkg::SUM_W-1:0] add_term;

    assign unused_sb = h_val[11 +: SAMPLE_BITS_W];

    sps_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .in_x      (seed_reg ^ bterm_reg ^ base_reg),
        .in_tag    (b_reg),
        .out_valid (h_valid),
        .out_h     (h_val),
        .out_tag   (h_tag)
    );

    sps_ram #(
        .WIDTH (sps_pkg::SUM_W),
        .DEPTH (sps_pkg::MAX_SIG_BITS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // weight = (2^SAMPLE_BITS - 1) + 2m, always positive, up to 196605
    assign weight = 19'sd65535 + $signed({2'b00, unused_sb, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= h_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_b_reg   <= h_tag;
        p_neg_reg <= h_val[0];
        prod_reg  <= 34'(elem_reg) * 34'(weight);
    end

    always_comb
    begin
        add_term = p_neg_reg ? sps_pkg::SUM_W'(-prod_reg) : sps_pkg::SUM_W'(prod_reg);
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(b_reg);
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = p_valid_reg;
            ram_waddr = AW'(p_b_reg);
            ram_wdata = ram_rdata + add_term;
        end
        // read for the accumulate stage, or for the sign readout
        ram_raddr = (state_reg == ST_SIG) ? AW'(b_reg) : AW'(h_tag);
    end

    assign issue     = (state_reg == ST_ISSUE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        iterm_next    = iterm_reg;
        base_next     = base_reg;
        bterm_next    = bterm_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        elem_next     = elem_reg;
        sig_next      = sig_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        inflight_next = inflight_reg + 7'(issue) - 7'(p_valid_reg);

        // sign bit capture, in the cycle after each readout
        if (rdp_reg && !ram_rdata[sps_pkg::SUM_W-1])
        begin
            sig_next[rdi_reg] = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                b_next = b_reg + 6'd1;
                if (b_reg == 6'(sps_pkg::MAX_SIG_BITS - 1))
                begin
                    b_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    elem_next  = $signed(s_tdata);
                    last_next  = s_tlast;
                    b_next     = '0;
                    bterm_next = '0;
                    if (count_reg < sps_pkg::CNT_W'(sps_pkg::MAX_DIM))
                    begin
                        base_next  = iterm_reg;
                        iterm_next = iterm_reg + sps_pkg::IDX_MUL;
                        count_next = count_reg + 1'b1;
                        if (sig_bits_reg != '0)
                            state_next = ST_ISSUE;
                        else if (s_tlast)
                            state_next = ST_SIG;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (s_tlast)
                            state_next = ST_SIG;
                    end
                    if (s_tlast)
                        sig_next = '0;
                end
            end
            ST_ISSUE:
            begin
                b_next     = b_reg + 6'd1;
                bterm_next = bterm_reg + sps_pkg::BIT_MUL;
                if (b_reg == sig_bits_reg - 6'd1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                b_next = '0;
                if (inflight_next == '0)
                    state_next = last_reg ? ST_SIG : ST_IDLE;
            end
            ST_SIG:
            begin
                b_next = b_reg + 6'd1;
                if (sig_bits_reg == '0)
                    state_next = ST_LOAD;
                else if (b_reg == sig_bits_reg - 6'd1)
                    state_next = ST_SIGW;
            end
            ST_SIGW:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, ovf_reg, count_reg, sig_reg};
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    iterm_next   = '0;
                    b_next       = '0;
                    state_next   = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            iterm_reg    <= '0;
            b_reg        <= '0;
            inflight_reg <= '0;
            rdp_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            sig_bits_reg <= 6'd16;
            seed_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            iterm_reg    <= iterm_next;
            b_reg        <= b_next;
            inflight_reg <= inflight_next;
            rdp_reg      <= (state_reg == ST_SIG) && (sig_bits_reg != '0);
            m_valid_reg  <= m_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == sps_pkg::REG_SIG_BITS)
                    sig_bits_reg <= cfg_data[5:0];
                else
                    seed_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        bterm_reg  <= bterm_next;
        last_reg   <= last_next;
        elem_reg   <= elem_next;
        sig_reg    <= sig_next;
        m_data_reg <= m_data_next;
        rdi_reg    <= b_reg;
    end

    // no sums in flight while waiting for an element
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> inflight_reg == '0)
        else $error("sums still in flight in idle");

    // memory writes stay inside the sum array
    a_waddr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ram_waddr < AW'(sps_pkg::MAX_SIG_BITS))
        else $error("sum write out of range");

    // accumulate writes never overlap the clearing pass or readout
    a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("accumulate write outside element processing");

    // a loaded result never carries a count beyond the limit
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> m_data_reg[75:63] <= 13'(sps_pkg::MAX_DIM))
        else $error("element total beyond limit");
endmodule

/* test/tb_top.sv */
// self-checking testbench for simhash_projection_signature
// depends on sps_pkg and the block's rtl; holds its own signature predictor
`timescale 1ns / 1ps

module tb_top;
    localparam int LIMIT_CYCLES = 20000000;
    localparam int SETTLE_CYCLES = 200;    // margin for element processing, sign readout, load and the clearing pass

    typedef struct packed {
        logic [62:0] signature;
        logic [12:0] total;
        logic        too_long;
    } signature_result_t;

    // predicts signatures from accepted elements and checks the block's results
    class signature_scoreboard;
        logic [63:0]       sums [sps_pkg::MAX_SIG_BITS];
        int unsigned       count;
        bit                overflow;
        logic [5:0]        sig_bits;
        logic [63:0]       seed;
        signature_result_t pending [$];
        int unsigned       failures;

        function void clear_vector();
            foreach (sums[b]) sums[b] = '0;
            count = 0;
            overflow = 0;
        endfunction

        function void reset();
            clear_vector();
            sig_bits = 6'd16;
            seed = '0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [63:0] data);
            if (idx == sps_pkg::REG_SIG_BITS)
                sig_bits = data[5:0];
            else
                seed = data;
        endfunction

        function logic [63:0] mix64(logic [63:0] x);
            x = x ^ (x >> 30);
            x = x * sps_pkg::MIX_C1;
            x = x ^ (x >> 27);
            x = x * sps_pkg::MIX_C2;
            x = x ^ (x >> 31);
            return x;
        endfunction

        function void note_element(logic [15:0] value, bit last);
            int                n;
            logic [63:0]       elem;
            logic [63:0]       h;
            logic [63:0]       w;
            logic [63:0]       prod;
            logic [63:0]       idx_term;
            signature_result_t r;
            n = (sig_bits > sps_pkg::MAX_SIG_BITS) ? sps_pkg::MAX_SIG_BITS : sig_bits;
            elem = {{48{value[15]}}, value};
            if (count < sps_pkg::MAX_DIM)
            begin
                idx_term = 64'(count) * sps_pkg::IDX_MUL;
                for (int b = 0; b < n; b++)
                begin
                    h = mix64(seed ^ (64'(b) * sps_pkg::BIT_MUL) ^ idx_term);
                    w = 64'hFFFF + 2 * ((h >> 11) & 64'hFFFF);
                    prod = elem * w;
                    if (h[0])
                        prod = -prod;
                    sums[b] = sums[b] + prod;
                end
                count++;
            end
            else
            begin
                overflow = 1;
            end
            if (last)
            begin
                r = '0;
                for (int b = 0; b < n; b++)
                    r.signature[b] = ~sums[b][63];
                r.total = count[12:0];
                r.too_long = overflow;
                pending = {pending, r};
                clear_vector();
            end
        endfunction

        function void check_result(logic [79:0] data);
            signature_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction %h", data);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (data[62:0] !== e.signature)
            begin
                $error("signature_value expected %h actual %h", e.signature, data[62:0]);
                failures++;
            end
            if (data[75:63] !== e.total)
            begin
                $error("element_total expected %0d actual %0d", e.total, data[75:63]);
                failures++;
            end
            if (data[76] !== e.too_long)
            begin
                $error("too_long expected %0d actual %0d", e.too_long, data[76]);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;  // [15:0] element_value
    logic        s_tlast = 0;   // last_element
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [79:0] m_tdata;       // [62:0] signature_value, [75:63] element_total, [76] too_long
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = sps_pkg::REG_SIG_BITS;
    logic [63:0] cfg_data = '0;

    signature_scoreboard sb = new();
    int  tx_idle = 0;           // percent of cycles the sender holds back
    int  rx_idle = 0;           // percent of cycles the receiver stalls
    bit  rx_hold = 0;           // long receiver hold-off to back up the block
    int  cycles = 0;

    simhash_projection_signature dut (.*);

    always #1 clk = ~clk;

    // receiver side: random stalls, plus the long hold-off
    always @(negedge clk)
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle);

    // result transactions go straight to the scoreboard
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one element transaction; returns at the falling edge after acceptance
    task automatic send_element(logic [15:0] value, bit last);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= value;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_element(value, last);
        @(negedge clk);
    endtask

    // settle: all results in, then let the clearing pass finish
    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // one config transaction; drops valid and lets the bus go idle before returning
    task automatic write_reg(logic [0:0] idx, logic [63:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic send_vector(int len, logic [15:0] fixed, bit use_fixed);
        logic [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            v = use_fixed ? fixed : 16'($urandom_range(0, 65535));
            send_element(v, i == len - 1);
        end
    endtask

    // random vectors: mostly short, some longer, extremes sprinkled in
    task automatic random_vectors(int items);
        int          sent;
        int          len;
        int          pick;
        logic [15:0] v;
        sent = 0;
        while (sent < items)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    v = 16'h8000;
                else if (pick == 1)
                    v = 16'h7FFF;
                else if (pick == 2)
                    v = '0;
                else
                    v = 16'($urandom_range(0, 65535));
                send_element(v, i == len - 1);
            end
            sent += len;
        end
    endtask

    task automatic random_config();
        write_reg(sps_pkg::REG_SIG_BITS, 64'($urandom_range(1, 63)));
        write_reg(sps_pkg::REG_SEED, {$urandom, $urandom});
        @(negedge clk);
    endtask

    initial
    begin
        sb.reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        wait_idle();

        // directed: field extremes, zero sum, zero and full bit counts, seed extremes
        send_vector(1, 16'h7FFF, 1);
        send_vector(1, 16'h8000, 1);
        send_vector(1, 16'h0000, 1);          // exact zero sum sets every bit in use
        send_vector(3, 16'hFFFF, 1);
        wait_idle();
        write_reg(sps_pkg::REG_SIG_BITS, 64'd63);
        write_reg(sps_pkg::REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_vector(2, 16'h8000, 1);
        send_vector(4, 16'h0, 0);
        wait_idle();
        write_reg(sps_pkg::REG_SIG_BITS, 64'd0);   // no bits in use, signature stays zero
        send_vector(3, 16'h0, 0);
        wait_idle();
        write_reg(sps_pkg::REG_SIG_BITS, 64'd1);
        write_reg(sps_pkg::REG_SEED, 64'd0);
        send_vector(2, 16'h1234, 1);
        send_vector(sps_pkg::MAX_DIM + 1, 16'h0, 0);   // overlong vector, extra dropped
        wait_idle();

        // phase 1: sender idles lightly, receiver often, with a long hold-off
        random_config();
        tx_idle = 27;
        rx_idle = 46;
        fork
            begin
                rx_hold = 1;
                repeat (3000) @(posedge clk);
                rx_hold = 0;
            end
        join_none
        random_vectors(400);
        wait_idle();

        // phase 2: roles swapped
        random_config();
        tx_idle = 46;
        rx_idle = 27;
        random_vectors(400);
        wait_idle();

        // phase 3: full rate both ways, widest signature
        write_reg(sps_pkg::REG_SIG_BITS, 64'd63);
        write_reg(sps_pkg::REG_SEED, {$urandom, $urandom});
        tx_idle = 0;
        rx_idle = 0;
        random_vectors(400);
        wait_idle();

        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* simhash_projection_signature.f */
hw/rtl/sps_pkg.sv
hw/rtl/sps_ram.sv
hw/rtl/sps_hash.sv
hw/rtl/simhash_projection_signature.sv
test/tb_top.sv
